FILE: rtl/core/pba_pkg.sv
// Shared constants, types and helper functions for the pixel brightness adjuster.
`timescale 1ns / 1ps

package pba_pkg;

    // Fixed-point resolution of luminance and goal
    localparam int FRAC_BITS_DEF = 16;

    // Pixel layout
    localparam int CH_N = 3;
    localparam int CH_W = 8;
    localparam int PIX_W = CH_N * CH_W;

    // Configuration registers
    localparam int REG_W = 17;
    localparam logic [REG_W-1:0] REG_MAX = 17'd65536;
    localparam logic [REG_W-1:0] TARGET_RESET = 17'd32768;
    localparam logic [REG_W-1:0] EFFECT_RESET = 17'd65536;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EFFECT = 1'b1;

    // Luminance weights in millionths
    localparam longint unsigned W_RED_MICRO = 64'd212655;
    localparam longint unsigned W_GREEN_MICRO = 64'd715158;

    // Quotient bits produced by each divider (one spare bit above a byte)
    localparam int DIV_Q_W = 9;

    // Queue between the classifier and the scaler
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // What the back end has to do with a pixel
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SCALE,
        KIND_CAP
    } kind_t;

    // Weight rounded to nearest at the given fraction width
    function automatic longint unsigned weight_q(input longint unsigned micro, input int frac);
        return ((micro << frac) + 64'd500000) / 64'd1000000;
    endfunction

endpackage

FILE: rtl/core/pba_luma.sv
// Two-stage luminance unit: weighted channel sum, then exact division by 255.
`timescale 1ns / 1ps

module pba_luma #(
    parameter int FRAC_BITS = pba_pkg::FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         en,
    input  logic [pba_pkg::CH_N-1:0][pba_pkg::CH_W-1:0]  pix_i,
    output logic [FRAC_BITS:0]                           y_o
);

    localparam int QW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 8;
    localparam int PW = 2 * SW + 1;
    localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
    localparam longint unsigned WR_L = pba_pkg::weight_q(pba_pkg::W_RED_MICRO, FRAC_BITS);
    localparam longint unsigned WG_L = pba_pkg::weight_q(pba_pkg::W_GREEN_MICRO, FRAC_BITS);
    localparam longint unsigned WB_L = ONE_L - WR_L - WG_L;
    // Reciprocal of 255 rounded up, exact for every sum below 2^SW
    localparam longint unsigned RECIP_L = ((64'd1 << (SW + 8)) + 64'd254) / 64'd255;
    localparam logic [SW-1:0] WR_C = SW'(WR_L);
    localparam logic [SW-1:0] WG_C = SW'(WG_L);
    localparam logic [SW-1:0] WB_C = SW'(WB_L);
    localparam logic [PW-1:0] RECIP_C = PW'(RECIP_L);

    logic [SW-1:0] sum_next;
    logic [SW-1:0] sum_reg;
    logic [PW-1:0] prod;
    logic [QW-1:0] y_next;
    logic [QW-1:0] y_reg;

    // Weighted sum of the three channels
    assign sum_next = WR_C * SW'(pix_i[0]) + WG_C * SW'(pix_i[1]) + WB_C * SW'(pix_i[2]);

    // Divide by 255 through the reciprocal
    assign prod = PW'(sum_reg) * RECIP_C;
    assign y_next = QW'(prod >> (SW + 8));

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            y_reg <= y_next;
        end
    end

    assign y_o = y_reg;

endmodule

FILE: rtl/core/pba_div.sv
// Pipelined restoring divider: three numerators over one shared denominator, a bit per stage.
`timescale 1ns / 1ps

module pba_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 17,
    parameter int Q_W = pba_pkg::DIV_Q_W,
    parameter int SIDE_W = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 valid_i,
    input  logic [pba_pkg::CH_N-1:0][NUM_W-1:0]  num_i,
    input  logic [DEN_W-1:0]                     den_i,
    input  logic [SIDE_W-1:0]                    side_i,
    output logic                                 valid_o,
    output logic [pba_pkg::CH_N-1:0][Q_W-1:0]    q_o,
    output logic [SIDE_W-1:0]                    side_o
);

    localparam int LANES = pba_pkg::CH_N;
    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [LANES-1:0][RW-1:0]  rem_reg [Q_W+1];
    logic [LANES-1:0][Q_W-1:0] quo_reg [Q_W+1];
    logic [DEN_W-1:0]          den_reg [Q_W+1];
    logic [SIDE_W-1:0]         side_reg [Q_W+1];
    logic [Q_W:0]              vld_reg;
    logic [RW-1:0]             trial [Q_W];
    logic [LANES-1:0]          ge [Q_W];

    // Advance the valid flags with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Q_W-1:0], valid_i};
        end
    end

    // Trial subtrahend and compare for every stage, most significant bit first
    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            trial[k] = RW'(den_reg[k]) << (Q_W - 1 - k);
            for (int l = 0; l < LANES; l++) begin
                ge[k][l] = (rem_reg[k][l] >= trial[k]);
            end
        end
    end

    // Capture the operands, then one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= RW'(num_i[l]);
                quo_reg[0][l] <= '0;
            end
            den_reg[0] <= den_i;
            side_reg[0] <= side_i;
            for (int k = 0; k < Q_W; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k+1][l] <= ge[k][l] ? rem_reg[k][l] - trial[k] : rem_reg[k][l];
                    quo_reg[k+1][l] <= {quo_reg[k][l][Q_W-2:0], ge[k][l]};
                end
                den_reg[k+1] <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign valid_o = vld_reg[Q_W];
    assign q_o = quo_reg[Q_W];
    assign side_o = side_reg[Q_W];

endmodule

FILE: rtl/core/pba_front.sv
// Front end: accepts pixels, finds luminance and goal, and classifies each pixel.
`timescale 1ns / 1ps

module pba_front #(
    parameter int FRAC_BITS = pba_pkg::FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid_i,
    output logic                                         s_ready_o,
    input  logic [pba_pkg::CH_N-1:0][pba_pkg::CH_W-1:0]  pix_i,
    input  logic [pba_pkg::REG_W-1:0]                    target_i,
    input  logic [pba_pkg::REG_W-1:0]                    effect_i,
    output logic                                         push_o,
    input  logic                                         full_i,
    output pba_pkg::kind_t                               kind_o,
    output logic [pba_pkg::CH_N-1:0][pba_pkg::CH_W-1:0]  pix_o,
    output logic [FRAC_BITS:0]                           y_o,
    output logic [FRAC_BITS:0]                           goal_o,
    output logic [pba_pkg::CH_W-1:0]                     max_o
);

    localparam int QW = FRAC_BITS + 1;
    localparam int UP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN_SH = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int XW = pba_pkg::REG_W + UP_SH;
    localparam int CW = FRAC_BITS + 10;

    typedef logic [pba_pkg::CH_N-1:0][pba_pkg::CH_W-1:0] pix_t;

    logic                    en;
    logic                    accept;
    logic [pba_pkg::CH_W-1:0] max_in;
    logic                    va_reg, vb_reg, vc_reg;
    pix_t                    pix_a_reg, pix_b_reg, pix_c_reg;
    logic [pba_pkg::CH_W-1:0] max_a_reg, max_b_reg, max_c_reg;
    logic [QW-1:0]           y_b;
    logic [QW-1:0]           y_c_reg;
    logic [QW-1:0]           goal_next, goal_c_reg;
    logic [pba_pkg::REG_W-1:0] t_clamp, e_clamp;
    logic [XW-1:0]           t_wide, e_wide;
    logic [QW-1:0]           t_q, e_q, diff, step;
    logic [2*QW-1:0]         prod;
    logic [CW-1:0]           cap_lhs, cap_rhs;

    // Stall the whole front while the last stage cannot hand over
    assign en = !vc_reg || !full_i;
    assign s_ready_o = en;
    assign accept = s_valid_i && en;

    // Largest channel
    always_comb begin
        max_in = pix_i[0];
        if (pix_i[1] > max_in) max_in = pix_i[1];
        if (pix_i[2] > max_in) max_in = pix_i[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= accept;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    pba_luma #(
        .FRAC_BITS(FRAC_BITS)
    ) u_luma (
        .aclk  (aclk),
        .en    (en),
        .pix_i (pix_i),
        .y_o   (y_b)
    );

    // Clamp the registers to 65536 and bring them to internal fraction width
    always_comb begin
        t_clamp = (target_i > pba_pkg::REG_MAX) ? pba_pkg::REG_MAX : target_i;
        e_clamp = (effect_i > pba_pkg::REG_MAX) ? pba_pkg::REG_MAX : effect_i;
        t_wide = XW'(t_clamp) << UP_SH;
        e_wide = XW'(e_clamp) << UP_SH;
        t_q = QW'(t_wide >> DN_SH);
        e_q = QW'(e_wide >> DN_SH);
    end

    // Move the luminance toward the target, truncating the step toward the luminance
    always_comb begin
        diff = (t_q >= y_b) ? t_q - y_b : y_b - t_q;
        prod = (2*QW)'(e_q) * (2*QW)'(diff);
        step = QW'(prod >> FRAC_BITS);
        goal_next = (t_q >= y_b) ? y_b + step : y_b - step;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_a_reg <= pix_i;
            max_a_reg <= max_in;
            pix_b_reg <= pix_a_reg;
            max_b_reg <= max_a_reg;
            pix_c_reg <= pix_b_reg;
            max_c_reg <= max_b_reg;
            y_c_reg <= y_b;
            goal_c_reg <= goal_next;
        end
    end

    // Classify: pass through, plain scale, or capped scale with blend
    always_comb begin
        cap_lhs = (CW'(goal_c_reg) * CW'(max_c_reg)) << 1;
        cap_rhs = CW'(y_c_reg) * CW'(10'd511);
        priority if (max_c_reg == '0 || y_c_reg == '0 || goal_c_reg == y_c_reg) begin
            kind_o = pba_pkg::KIND_PASS;
        end else if (cap_lhs > cap_rhs) begin
            kind_o = pba_pkg::KIND_CAP;
        end else begin
            kind_o = pba_pkg::KIND_SCALE;
        end
    end

    assign push_o = vc_reg && !full_i;
    assign pix_o = pix_c_reg;
    assign y_o = y_c_reg;
    assign goal_o = goal_c_reg;
    assign max_o = max_c_reg;

endmodule

FILE: rtl/core/pba_back.sv
// Back end: scales, finds the new luminance and blends, then holds the result word.
`timescale 1ns / 1ps

module pba_back #(
    parameter int FRAC_BITS = pba_pkg::FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         avail_i,
    output logic                                         pop_o,
    input  pba_pkg::kind_t                               kind_i,
    input  logic [pba_pkg::CH_N-1:0][pba_pkg::CH_W-1:0]  pix_i,
    input  logic [FRAC_BITS:0]                           y_i,
    input  logic [FRAC_BITS:0]                           goal_i,
    input  logic [pba_pkg::CH_W-1:0]                     max_i,
    output logic                                         m_valid_o,
    input  logic                                         m_ready_i,
    output logic [pba_pkg::CH_N-1:0][pba_pkg::CH_W-1:0]  pix_o
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 8;
    localparam int DQ = pba_pkg::DIV_Q_W;
    localparam int KW = 2;
    localparam int SA_W = KW + pba_pkg::PIX_W + QW;
    localparam int SB_W = 2 + pba_pkg::PIX_W;
    localparam int CH_N = pba_pkg::CH_N;
    localparam logic [QW-1:0] ONE_C = QW'(1) << FRAC_BITS;

    typedef logic [CH_N-1:0][pba_pkg::CH_W-1:0] pix_t;

    logic                   adv;
    logic [CH_N-1:0][NW-1:0] num_a, num_b;
    logic [QW-1:0]          den_a, den_b;
    logic [SA_W-1:0]        side_a_in, side_a_out;
    logic [SB_W-1:0]        side_b_in, side_b_out;
    logic                   va, vb;
    logic [CH_N-1:0][DQ-1:0] qa, qb;
    pba_pkg::kind_t         kind_a;
    pix_t                   pix_a, s_a, fixed, fixed_b, result;
    logic [QW-1:0]          goal_a;
    logic [QW-1:0]          y2;
    logic                   l1_v_reg, l2_v_reg;
    pba_pkg::kind_t         l1_kind_reg, l2_kind_reg;
    pix_t                   l1_pix_reg, l2_pix_reg, l1_s_reg, l2_s_reg;
    logic [QW-1:0]          l1_goal_reg, l2_goal_reg;
    logic                   white, use_div, white_b, use_div_b;
    logic [QW-1:0]          keep;
    logic                   out_v_reg;
    pix_t                   out_pix_reg;

    // Move everything on whenever the output word is free or being taken
    assign adv = !out_v_reg || m_ready_i;
    assign pop_o = adv && avail_i;

    // First division: channel times goal over luminance, or channel times 511 over twice max
    always_comb begin
        for (int l = 0; l < CH_N; l++) begin
            if (kind_i == pba_pkg::KIND_CAP) begin
                num_a[l] = NW'(pix_i[l]) * NW'(10'd511);
            end else begin
                num_a[l] = NW'(pix_i[l]) * NW'(goal_i);
            end
        end
        den_a = (kind_i == pba_pkg::KIND_CAP) ? QW'({max_i, 1'b0}) : y_i;
        side_a_in = {kind_i, pix_i, goal_i};
    end

    pba_div #(
        .NUM_W  (NW),
        .DEN_W  (QW),
        .Q_W    (DQ),
        .SIDE_W (SA_W)
    ) u_div_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .valid_i (pop_o),
        .num_i   (num_a),
        .den_i   (den_a),
        .side_i  (side_a_in),
        .valid_o (va),
        .q_o     (qa),
        .side_o  (side_a_out)
    );

    // Saturate the scaled channels to a byte
    always_comb begin
        kind_a = pba_pkg::kind_t'(side_a_out[SA_W-1 -: KW]);
        pix_a = side_a_out[QW +: pba_pkg::PIX_W];
        goal_a = side_a_out[QW-1:0];
        for (int l = 0; l < CH_N; l++) begin
            s_a[l] = (qa[l] > DQ'(255)) ? 8'hFF : qa[l][7:0];
        end
    end

    // Luminance of the scaled pixel
    pba_luma #(
        .FRAC_BITS(FRAC_BITS)
    ) u_luma (
        .aclk  (aclk),
        .en    (adv),
        .pix_i (s_a),
        .y_o   (y2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_v_reg <= 1'b0;
            l2_v_reg <= 1'b0;
        end else if (adv) begin
            l1_v_reg <= va;
            l2_v_reg <= l1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l1_kind_reg <= kind_a;
            l1_pix_reg <= pix_a;
            l1_s_reg <= s_a;
            l1_goal_reg <= goal_a;
            l2_kind_reg <= l1_kind_reg;
            l2_pix_reg <= l1_pix_reg;
            l2_s_reg <= l1_s_reg;
            l2_goal_reg <= l1_goal_reg;
        end
    end

    // Second division: blend toward white (rounded up) or toward black
    always_comb begin
        white = (y2 < l2_goal_reg);
        keep = ONE_C - l2_goal_reg;
        den_b = white ? ONE_C - y2 : y2;
        for (int l = 0; l < CH_N; l++) begin
            if (white) begin
                num_b[l] = NW'(8'd255 - l2_s_reg[l]) * NW'(keep) + NW'(den_b) - NW'(1);
            end else begin
                num_b[l] = NW'(l2_s_reg[l]) * NW'(l2_goal_reg);
            end
        end
        use_div = (l2_kind_reg == pba_pkg::KIND_CAP);
        fixed = (l2_kind_reg == pba_pkg::KIND_PASS) ? l2_pix_reg : l2_s_reg;
        side_b_in = {use_div, white, fixed};
    end

    pba_div #(
        .NUM_W  (NW),
        .DEN_W  (QW),
        .Q_W    (DQ),
        .SIDE_W (SB_W)
    ) u_div_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .valid_i (l2_v_reg),
        .num_i   (num_b),
        .den_i   (den_b),
        .side_i  (side_b_in),
        .valid_o (vb),
        .q_o     (qb),
        .side_o  (side_b_out)
    );

    // Pick the finished channels
    always_comb begin
        use_div_b = side_b_out[SB_W-1];
        white_b = side_b_out[SB_W-2];
        fixed_b = side_b_out[pba_pkg::PIX_W-1:0];
        for (int l = 0; l < CH_N; l++) begin
            if (!use_div_b) begin
                result[l] = fixed_b[l];
            end else if (white_b) begin
                result[l] = (qb[l] > DQ'(255)) ? 8'h00 : 8'hFF - qb[l][7:0];
            end else begin
                result[l] = (qb[l] > DQ'(255)) ? 8'hFF : qb[l][7:0];
            end
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= vb;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_pix_reg <= result;
        end
    end

    assign m_valid_o = out_v_reg;
    assign pix_o = out_pix_reg;

endmodule

FILE: rtl/core/pixel_brightness_adjust.sv
// Top level of the pixel brightness adjuster: config registers, queue and the two halves.
`timescale 1ns / 1ps

// Moves the luminance of each 8-bit sRGB pixel toward a target luminance.
// Input stream s_*: one pixel per word, tdata = {blue, green, red}.
// Output stream m_*: one adjusted pixel per input word, same packing, same order.
// Configuration: cfg_wr_en with cfg_addr 0 writes target_brightness, 1 writes
// effect_ratio (both Q1.16, 17 bits); write only while no pixel is in flight.
// Throughput: one pixel per clock while m_tready is not held low. Each pixel
// runs a pipeline whose length is set by the two pipelined dividers (ten
// stages each) and the two luminance units.
// The front end classifies pixels and hands them to the back end through a
// four-entry queue. When the receiver holds m_tready low, the back end freezes
// with its output word held; the front end keeps accepting until the queue is full
// and the last of its own three stages holds a pixel, then drops s_tready.
// Reset (aresetn low, synchronous) empties all stages and the queue and loads
// target 32768 and effect 65536; s_tready is high in the cycle after reset.
module pixel_brightness_adjust #(
    parameter int FRAC_BITS = pba_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,     // red_in, green_in, blue_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,     // red_out, green_out, blue_out
    input  logic                                cfg_wr_en,
    input  logic [pba_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [pba_pkg::REG_W-1:0]           cfg_wr_data
);

    localparam int QW = FRAC_BITS + 1;
    localparam int DEPTH = pba_pkg::QUEUE_DEPTH;
    localparam int PW = pba_pkg::QUEUE_PTR_W;
    localparam int CNTW = pba_pkg::QUEUE_CNT_W;

    typedef logic [pba_pkg::CH_N-1:0][pba_pkg::CH_W-1:0] pix_t;

    logic [pba_pkg::REG_W-1:0] target_reg, effect_reg;
    logic                      push, pop, full, empty;
    pba_pkg::kind_t            f_kind;
    pix_t                      f_pix;
    logic [QW-1:0]             f_y, f_goal;
    logic [pba_pkg::CH_W-1:0]  f_max;
    pba_pkg::kind_t            q_kind_reg [DEPTH];
    pix_t                      q_pix_reg [DEPTH];
    logic [QW-1:0]             q_y_reg [DEPTH];
    logic [QW-1:0]             q_goal_reg [DEPTH];
    logic [pba_pkg::CH_W-1:0]  q_max_reg [DEPTH];
    logic [PW-1:0]             wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]           count_reg;
    pix_t                      out_pix;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= pba_pkg::TARGET_RESET;
            effect_reg <= pba_pkg::EFFECT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pba_pkg::CFG_TARGET: target_reg <= cfg_wr_data;
                pba_pkg::CFG_EFFECT: effect_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    pba_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_tvalid),
        .s_ready_o (s_tready),
        .pix_i     (s_tdata),
        .target_i  (target_reg),
        .effect_i  (effect_reg),
        .push_o    (push),
        .full_i    (full),
        .kind_o    (f_kind),
        .pix_o     (f_pix),
        .y_o       (f_y),
        .goal_o    (f_goal),
        .max_o     (f_max)
    );

    // Queue between classifier and scaler
    assign full = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_kind_reg[wr_ptr_reg] <= f_kind;
            q_pix_reg[wr_ptr_reg] <= f_pix;
            q_y_reg[wr_ptr_reg] <= f_y;
            q_goal_reg[wr_ptr_reg] <= f_goal;
            q_max_reg[wr_ptr_reg] <= f_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop) begin
                count_reg <= count_reg + CNTW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    pba_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .avail_i   (!empty),
        .pop_o     (pop),
        .kind_i    (q_kind_reg[rd_ptr_reg]),
        .pix_i     (q_pix_reg[rd_ptr_reg]),
        .y_i       (q_y_reg[rd_ptr_reg]),
        .goal_i    (q_goal_reg[rd_ptr_reg]),
        .max_i     (q_max_reg[rd_ptr_reg]),
        .m_valid_o (m_tvalid),
        .m_ready_i (m_tready),
        .pix_o     (out_pix)
    );

    assign m_tdata = out_pix;

endmodule

FILE: rtl/core/pba_check.sv
// Port-level checker for the pixel brightness adjuster, bound to the top level.
`timescale 1ns / 1ps

module pba_check (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [23:0]                     m_tdata,
    input logic                            cfg_wr_en,
    input logic [pba_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input logic [pba_pkg::REG_W-1:0]       cfg_wr_data
);

    logic [6:0] inflight_reg;
    logic       in_acc, out_acc;

    assign in_acc = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Count words accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else if (in_acc && !out_acc) begin
            inflight_reg <= inflight_reg + 7'd1;
        end else if (out_acc && !in_acc) begin
            inflight_reg <= inflight_reg - 7'd1;
        end
    end

    // No output word without a pixel behind it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (inflight_reg != 7'd0))
        else $error("output word with no pixel in flight");

    // Reset empties the output and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("bad state after reset");

    // A stalled output word stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    // Register writes land only on an empty pipeline, with known index and data
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |-> (inflight_reg == 7'd0 && !$isunknown({cfg_addr, cfg_wr_data})))
        else $error("register write with pixels in flight");

endmodule

bind pixel_brightness_adjust pba_check u_check (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
);
